/* hdl/ptgc_pkg.sv */
package ptgc_pkg;

    // CORDIC depth; at most AtanDepth cells are built
    localparam int CordicStages = 16;
    localparam int AtanDepth    = 24;
    localparam int NumCells     = (CordicStages < AtanDepth) ? CordicStages : AtanDepth;
    localparam int StageW       = 5;

    localparam int GainW = 18;
    localparam int AngW  = 16;
    localparam int RateW = 16;
    localparam int ErrW  = 17;
    localparam int CosW  = 16;
    localparam int TrqW  = 32;
    localparam int CfgIdxW = 3;

    // angle constants at 30 fraction bits
    localparam logic signed [35:0] AngPi     = 36'sd3373259426;
    localparam logic signed [35:0] AngTwoPi  = 36'sd6746518852;
    localparam logic        [31:0] AngPiU    = 32'd3373259426;
    localparam logic        [31:0] AngHalfPi = 32'd1686629713;
    localparam logic signed [31:0] CordicGain = 32'sd652032874;

    // truncated atan(2^-i) at 30 fraction bits
    localparam logic signed [31:0] AtanTab [AtanDepth] = '{
        32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
        32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
        32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
        32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
        32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
        32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
    };

    // register reset values
    localparam logic [GainW-1:0] RstPropGain    = 18'd160000;
    localparam logic [GainW-1:0] RstDerivGain   = 18'd12800;
    localparam logic [GainW-1:0] RstInertia     = 18'd23593;
    localparam logic [GainW-1:0] RstDamping     = 18'd6561;
    localparam logic [GainW-1:0] RstGravityGain = 18'd77070;

    typedef enum logic [CfgIdxW-1:0] {
        RegPropGain    = 3'd0,
        RegDerivGain   = 3'd1,
        RegInertia     = 3'd2,
        RegDamping     = 3'd3,
        RegGravityGain = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [GainW-1:0] prop_gain;
        logic [GainW-1:0] deriv_gain;
        logic [GainW-1:0] inertia;
        logic [GainW-1:0] damping;
        logic [GainW-1:0] gravity_gain;
    } t_gains;

    // one word moving down the CORDIC row, with its side data
    typedef struct packed {
        logic                    valid;
        logic                    neg;
        logic signed [31:0]      x;
        logic signed [31:0]      y;
        logic signed [31:0]      z;
        logic signed [RateW-1:0] rate;
        logic signed [ErrW-1:0]  err;
    } t_cell;

endpackage

/* hdl/pd_torque_gravity_comp_unit.sv */
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+---------------------------------------------
// input     | i_in_valid / o_in_stall        | i_joint_angle, i_angular_rate, i_target_angle
// output    | o_out_valid / i_out_stall      | o_torque_cmd, o_saturated
// config    | i_cfg_we                       | i_cfg_index, i_cfg_data
//
// One word enters per cycle while the output is not stalled; each passes through
// one range-reduction stage, one cell per CORDIC rotation, four multiply/sum stages.
// Reset is synchronous, active low; it clears valid bits and loads the gain registers.
// A stall on the output freezes the whole pipeline while a result waits; the input
// is stalled only then, so words keep flowing into bubbles and behind taken results.
module pd_torque_gravity_comp_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_joint_angle,
    input  logic signed [15:0]    i_angular_rate,
    input  logic signed [15:0]    i_target_angle,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [31:0]    o_torque_cmd,
    output logic                  o_saturated,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [17:0]           i_cfg_data
);

    logic              w_en;
    ptgc_pkg::t_gains  r_gains;
    ptgc_pkg::t_cell   w_chain [ptgc_pkg::NumCells+1];

    // hold everything while a finished word is stalled
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // write gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop_gain    <= ptgc_pkg::RstPropGain;
            r_gains.deriv_gain   <= ptgc_pkg::RstDerivGain;
            r_gains.inertia      <= ptgc_pkg::RstInertia;
            r_gains.damping      <= ptgc_pkg::RstDamping;
            r_gains.gravity_gain <= ptgc_pkg::RstGravityGain;
        end else if (i_cfg_we) begin
            case (ptgc_pkg::t_reg_idx'(i_cfg_index))
                ptgc_pkg::RegPropGain:    r_gains.prop_gain    <= i_cfg_data;
                ptgc_pkg::RegDerivGain:   r_gains.deriv_gain   <= i_cfg_data;
                ptgc_pkg::RegInertia:     r_gains.inertia      <= i_cfg_data;
                ptgc_pkg::RegDamping:     r_gains.damping      <= i_cfg_data;
                ptgc_pkg::RegGravityGain: r_gains.gravity_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // reduce the angle and seed the row
    ptgc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_in_valid),
        .i_joint_angle  (i_joint_angle),
        .i_angular_rate (i_angular_rate),
        .i_target_angle (i_target_angle),
        .o_cell         (w_chain[0])
    );

    // row of CORDIC cells, one rotation each
    for (genvar k = 0; k < ptgc_pkg::NumCells; k++) begin : g_cell
        ptgc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (ptgc_pkg::StageW'(k)),
            .i_cell  (w_chain[k]),
            .o_cell  (w_chain[k+1])
        );
    end

    // products, sum, rounding and output register
    ptgc_tail u_tail (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_cell       (w_chain[ptgc_pkg::NumCells]),
        .i_gains      (r_gains),
        .o_valid      (o_out_valid),
        .o_torque_cmd (o_torque_cmd),
        .o_saturated  (o_saturated)
    );

    // no word leaves in the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a clipped word never carries an in-range value
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_torque_cmd != 32'sh7FFFFFFF && o_torque_cmd != 32'sh80000000)
            |-> !o_saturated)
        else $error("saturated flag on in-range torque");

endmodule

/* hdl/ptgc_front.sv */
module ptgc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [15:0]     i_joint_angle,
    input  logic signed [15:0]     i_angular_rate,
    input  logic signed [15:0]     i_target_angle,
    output ptgc_pkg::t_cell        o_cell
);

    logic signed [16:0] w_ang;
    logic        [16:0] w_mag;
    logic signed [35:0] w_z;
    logic signed [35:0] w_wrap;
    logic        [31:0] n_z1;
    logic signed [16:0] n_err;

    logic               r_valid;
    logic        [31:0] r_z1;
    logic signed [15:0] r_rate;
    logic signed [16:0] r_err;

    // take magnitude, wrap once by two pi, take magnitude again
    always_comb begin
        w_ang  = 17'(i_joint_angle);
        w_mag  = (w_ang < 0) ? 17'(-w_ang) : 17'(w_ang);
        w_z    = $signed({1'b0, w_mag, 18'b0});
        w_wrap = (w_z > ptgc_pkg::AngPi) ? (w_z - ptgc_pkg::AngTwoPi) : w_z;
        n_z1   = (w_wrap < 0) ? 32'(-w_wrap) : 32'(w_wrap);
        n_err  = 17'(i_target_angle) - 17'(i_joint_angle);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z1   <= n_z1;
            r_rate <= i_angular_rate;
            r_err  <= n_err;
        end
    end

    // fold into the first quadrant and seed the rotation
    always_comb begin
        o_cell.valid = r_valid;
        o_cell.rate  = r_rate;
        o_cell.err   = r_err;
        o_cell.x     = ptgc_pkg::CordicGain;
        o_cell.y     = '0;
        if (r_z1 > ptgc_pkg::AngHalfPi) begin
            o_cell.z   = $signed(ptgc_pkg::AngPiU - r_z1);
            o_cell.neg = 1'b1;
        end else begin
            o_cell.z   = $signed(r_z1);
            o_cell.neg = 1'b0;
        end
    end

    // reduced angle never exceeds pi
    a_z1_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_z1 <= ptgc_pkg::AngPiU))
        else $error("reduced angle above pi");

endmodule

/* hdl/ptgc_cell.sv */
module ptgc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [ptgc_pkg::StageW-1:0]   i_stage,
    input  ptgc_pkg::t_cell               i_cell,
    output ptgc_pkg::t_cell               o_cell
);

    logic signed [31:0] w_dx;
    logic signed [31:0] w_dy;
    logic signed [31:0] w_atan;
    ptgc_pkg::t_cell    n_cell;
    ptgc_pkg::t_cell    r_cell;
    logic               r_valid;

    // rotate one micro-step toward zero residual angle
    always_comb begin
        w_dx   = i_cell.y >>> i_stage;
        w_dy   = i_cell.x >>> i_stage;
        w_atan = ptgc_pkg::AtanTab[i_stage];
        n_cell = i_cell;
        if (i_cell.z >= 0) begin
            n_cell.x = i_cell.x - w_dx;
            n_cell.y = i_cell.y + w_dy;
            n_cell.z = i_cell.z - w_atan;
        end else begin
            n_cell.x = i_cell.x + w_dx;
            n_cell.y = i_cell.y - w_dy;
            n_cell.z = i_cell.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    // hand the word on with its reset-cleared valid bit
    always_comb begin
        o_cell       = r_cell;
        o_cell.valid = r_valid;
    end

endmodule

/* hdl/ptgc_tail.sv */
module ptgc_tail (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  ptgc_pkg::t_cell       i_cell,
    input  ptgc_pkg::t_gains      i_gains,
    output logic                  o_valid,
    output logic signed [31:0]    o_torque_cmd,
    output logic                  o_saturated
);

    // stage 1: cosine rounding, proportional and derivative products
    logic signed [32:0] w_xsum;
    logic signed [16:0] w_xr;
    logic signed [15:0] w_xc;
    logic signed [18:0] w_kp;
    logic signed [18:0] w_kd;
    logic signed [15:0] n_cos;
    logic signed [34:0] n_p;
    logic signed [33:0] n_d;

    logic               r_s1_valid;
    logic signed [15:0] r_cos;
    logic signed [34:0] r_p;
    logic signed [33:0] r_d;
    logic signed [15:0] r_s1_rate;

    always_comb begin
        w_xsum = 33'(i_cell.x) + 33'sd32768;
        w_xr   = w_xsum[32:16];
        if (w_xr > 17'sd16384) begin
            w_xc = 16'sd16384;
        end else if (w_xr < -17'sd16384) begin
            w_xc = -16'sd16384;
        end else begin
            w_xc = 16'(w_xr);
        end
        n_cos = i_cell.neg ? -w_xc : w_xc;
        w_kp  = $signed({1'b0, i_gains.prop_gain});
        w_kd  = $signed({1'b0, i_gains.deriv_gain});
        n_p   = w_kp * i_cell.err;
        n_d   = w_kd * i_cell.rate;
    end

    // stage 2: control error, gravity and friction products
    logic signed [18:0] w_kg;
    logic signed [18:0] w_kf;
    logic signed [38:0] n_e;
    logic signed [33:0] n_gd;
    logic signed [33:0] n_fr;

    logic               r_s2_valid;
    logic signed [38:0] r_e;
    logic signed [33:0] r_gd;
    logic signed [33:0] r_fr;

    always_comb begin
        w_kg = $signed({1'b0, i_gains.gravity_gain});
        w_kf = $signed({1'b0, i_gains.damping});
        n_e  = 39'(r_p) - (39'(r_d) <<< 4);
        n_gd = w_kg * r_cos;
        n_fr = w_kf * r_s1_rate;
    end

    // stage 3: inertia split in two partial products, side terms summed
    logic signed [18:0] w_ehi;
    logic        [19:0] w_elo;
    logic signed [18:0] w_ki;
    logic signed [36:0] n_ph;
    logic        [37:0] n_pl;
    logic signed [46:0] n_sm;

    logic               r_s3_valid;
    logic signed [36:0] r_ph;
    logic        [37:0] r_pl;
    logic signed [46:0] r_sm;

    always_comb begin
        w_ehi = r_e[38:20];
        w_elo = r_e[19:0];
        w_ki  = $signed({1'b0, i_gains.inertia});
        n_ph  = w_ki * w_ehi;
        n_pl  = i_gains.inertia * w_elo;
        n_sm  = (47'(r_fr) <<< 12) + (47'(r_gd) <<< 6) + 47'sd524288;
    end

    // stage 4: final sum, round to Q15.16 and clip
    logic signed [57:0] w_total;
    logic signed [37:0] w_r;
    logic signed [31:0] n_trq;
    logic               n_sat;

    logic               r_s4_valid;
    logic signed [31:0] r_trq;
    logic               r_sat;

    always_comb begin
        w_total = (58'(r_ph) <<< 20) + 58'($signed({1'b0, r_pl})) + 58'(r_sm);
        w_r     = w_total[57:20];
        if (w_r > 38'sd2147483647) begin
            n_trq = 32'sh7FFFFFFF;
            n_sat = 1'b1;
        end else if (w_r < -38'sd2147483648) begin
            n_trq = 32'sh80000000;
            n_sat = 1'b1;
        end else begin
            n_trq = 32'(w_r);
            n_sat = 1'b0;
        end
    end

    // advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_cell.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // advance the data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos     <= n_cos;
            r_p       <= n_p;
            r_d       <= n_d;
            r_s1_rate <= i_cell.rate;
            r_e       <= n_e;
            r_gd      <= n_gd;
            r_fr      <= n_fr;
            r_ph      <= n_ph;
            r_pl      <= n_pl;
            r_sm      <= n_sm;
            r_trq     <= n_trq;
            r_sat     <= n_sat;
        end
    end

    assign o_valid      = r_s4_valid;
    assign o_torque_cmd = r_trq;
    assign o_saturated  = r_sat;

    // cosine stays within plus or minus one
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_cos <= 16'sd16384 && r_cos >= -16'sd16384))
        else $error("cosine out of range");

    // clipped result sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_valid && r_sat) |-> (r_trq == 32'sh7FFFFFFF || r_trq == 32'sh80000000))
        else $error("saturated word not at a limit");

endmodule

/* verif/ptgc_torque_checker.sv */
`timescale 1ns / 100ps

module ptgc_torque_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_joint_angle,
    input  logic signed [15:0] i_angular_rate,
    input  logic signed [15:0] i_target_angle,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_torque_cmd,
    input  logic               i_saturated,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    // angle constants at 30 fraction bits
    localparam longint PiQ30       = 64'sd3373259426;
    localparam longint TwoPiQ30    = 64'sd6746518852;
    localparam longint HalfPiQ30   = 64'sd1686629713;
    localparam longint CordicGainQ30 = 64'sd652032874;
    localparam int     CosStages   = ptgc_pkg::NumCells;

    localparam longint TorqueMax = 64'sd2147483647;
    localparam longint TorqueMin = -64'sd2147483648;

    // truncated atan(2^-i), 30 fraction bits
    localparam longint AtanQ30 [0:23] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [31:0] torque;
        logic               sat;
    } t_torque_word;

    logic [17:0] prop_gain;
    logic [17:0] deriv_gain;
    logic [17:0] inertia;
    logic [17:0] damping;
    logic [17:0] gravity_gain;

    t_torque_word torque_due_q [$];
    int           mismatches = 0;

    // cosine of a Q3.12 angle as Q1.14, rotation-mode CORDIC
    function automatic longint cosine_q14(input logic signed [15:0] ang);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z    = longint'(ang) * 262144;
        x    = CordicGainQ30;
        y    = 0;
        flip = 1'b0;
        // fold into [0, pi/2], cosine is even
        if (z < 0) z = -z;
        while (z > PiQ30) z -= TwoPiQ30;
        if (z < 0) z = -z;
        if (z > HalfPiQ30) begin
            z    = PiQ30 - z;
            flip = 1'b1;
        end
        for (int i = 0; i < CosStages; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= AtanQ30[i];
            end else begin
                x += dx;
                y -= dy;
                z += AtanQ30[i];
            end
        end
        x = (x + 32768) >>> 16;
        if (x > 16384) x = 16384;
        if (x < -16384) x = -16384;
        return flip ? -x : x;
    endfunction

    // PD torque plus viscous and gravity terms, summed at 36 fraction bits
    function automatic t_torque_word predict_torque(input logic signed [15:0] ang,
                                                    input logic signed [15:0] rate,
                                                    input logic signed [15:0] tgt);
        longint       prop;
        longint       deriv;
        longint       total;
        longint       rounded;
        t_torque_word w;
        prop    = longint'(prop_gain) * (longint'(tgt) - longint'(ang));
        deriv   = longint'(deriv_gain) * longint'(rate) * 16;
        total   = longint'(inertia) * (prop - deriv);
        total  += longint'(damping) * longint'(rate) * 4096;
        total  += longint'(gravity_gain) * cosine_q14(ang) * 64;
        rounded = (total + 524288) >>> 20;
        w.sat   = 1'b0;
        if (rounded > TorqueMax) begin
            rounded = TorqueMax;
            w.sat   = 1'b1;
        end
        if (rounded < TorqueMin) begin
            rounded = TorqueMin;
            w.sat   = 1'b1;
        end
        w.torque = rounded[31:0];
        return w;
    endfunction

    // track gains, queue predictions, compare taken results
    always @(posedge i_clk) begin : track
        t_torque_word want;
        if (!i_rst_n) begin
            prop_gain    <= 18'd160000;
            deriv_gain   <= 18'd12800;
            inertia      <= 18'd23593;
            damping      <= 18'd6561;
            gravity_gain <= 18'd77070;
            torque_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ptgc_pkg::RegPropGain:    prop_gain    <= i_cfg_data;
                    ptgc_pkg::RegDerivGain:   deriv_gain   <= i_cfg_data;
                    ptgc_pkg::RegInertia:     inertia      <= i_cfg_data;
                    ptgc_pkg::RegDamping:     damping      <= i_cfg_data;
                    ptgc_pkg::RegGravityGain: gravity_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (torque_due_q.size() == 0) begin
                    $display("%0t unexpected word: expected none, got torque %0d sat %0d",
                             $time, i_torque_cmd, i_saturated);
                    mismatches++;
                end else begin
                    want = torque_due_q.pop_front();
                    if (i_torque_cmd !== want.torque) begin
                        $display("%0t torque_cmd mismatch: expected %0d, got %0d",
                                 $time, want.torque, i_torque_cmd);
                        mismatches++;
                    end
                    if (i_saturated !== want.sat) begin
                        $display("%0t saturated mismatch: expected %0d, got %0d",
                                 $time, want.sat, i_saturated);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                torque_due_q.push_back(predict_torque(i_joint_angle, i_angular_rate,
                                                      i_target_angle));
            end
        end
        o_pending    <= torque_due_q.size();
        o_fail_count <= mismatches;
    end

endmodule

/* verif/pd_torque_gravity_comp_unit_test.sv */
`timescale 1ns / 100ps

module pd_torque_gravity_comp_unit_test;

    localparam int          PipeDepth     = ptgc_pkg::NumCells + 5;
    localparam int          QuietLimit    = 2000;
    localparam int          PhaseWords    = 240;
    localparam int          NumPhases     = 8;
    localparam int          StretchWords  = 60;
    localparam logic [17:0] GainMax       = 18'h3FFFF;
    localparam int          HalfPiQ12     = 6434;
    localparam int          PiQ12         = 12868;
    localparam int          FirstSpareIdx = int'(ptgc_pkg::RegGravityGain) + 1;
    localparam int          LastSpareIdx  = 2 ** ptgc_pkg::CfgIdxW - 1;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_joint_angle  = '0;
    logic signed [15:0] i_angular_rate = '0;
    logic signed [15:0] i_target_angle = '0;
    logic               o_out_valid;
    logic               i_out_stall    = 1'b0;
    logic signed [31:0] o_torque_cmd;
    logic               o_saturated;
    logic               i_cfg_we       = 1'b0;
    logic [2:0]         i_cfg_index    = '0;
    logic [17:0]        i_cfg_data     = '0;

    logic idling     = 1'b0;
    int   stall_left = 0;
    int   fail_count;
    int   pending_words;

    always #10 i_clk = ~i_clk;

    pd_torque_gravity_comp_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_joint_angle  (i_joint_angle),
        .i_angular_rate (i_angular_rate),
        .i_target_angle (i_target_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_torque_cmd   (o_torque_cmd),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    ptgc_torque_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_joint_angle  (i_joint_angle),
        .i_angular_rate (i_angular_rate),
        .i_target_angle (i_target_angle),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_torque_cmd   (o_torque_cmd),
        .i_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words)
    );

    // stall the result side in random bursts, started only while idling
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("pd_torque_gravity_comp_unit test failed");
        $finish;
    end

    // present one word and hold it until taken
    task automatic send_word(input logic signed [15:0] ang,
                             input logic signed [15:0] rate,
                             input logic signed [15:0] tgt);
        int gap;
        if (idling && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_joint_angle  <= ang;
        i_angular_rate <= rate;
        i_target_angle <= tgt;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold off input until every queued torque has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_gains(input logic [17:0] kp, input logic [17:0] kd,
                             input logic [17:0] inert, input logic [17:0] damp,
                             input logic [17:0] grav);
        write_reg(ptgc_pkg::RegPropGain, kp);
        write_reg(ptgc_pkg::RegDerivGain, kd);
        write_reg(ptgc_pkg::RegInertia, inert);
        write_reg(ptgc_pkg::RegDamping, damp);
        write_reg(ptgc_pkg::RegGravityGain, grav);
    endtask

    function automatic logic [17:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GainMax;
            2:       return 18'($urandom_range(0, 1023));
            default: return 18'($urandom);
        endcase
    endfunction

    // mostly full-range words, some extremes, small values and quadrant edges
    function automatic logic signed [15:0] pick_word(input bit angle_like);
        int base;
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($signed($urandom_range(0, 255)) - 128);
            2: begin
                if (!angle_like) return 16'($urandom);
                base = $urandom_range(0, 1) ? HalfPiQ12 : PiQ12;
                base = base + $urandom_range(0, 4) - 2;
                return 16'($urandom_range(0, 1) ? -base : base);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idling  <= 1'b1;

        // reset gains: zero, field extremes, angle wrap, quadrant edges
        send_word(16'sd0, 16'sd0, 16'sd0);
        send_word(16'sh7FFF, 16'sd0, 16'sh7FFF);
        send_word(16'sh8000, 16'sd0, 16'sh8000);
        send_word(16'sd6433, 16'sd0, 16'sd6433);
        send_word(16'sd6434, 16'sd0, 16'sd6434);
        send_word(-16'sd6434, 16'sd0, -16'sd6434);
        send_word(16'sd12867, 16'sd0, 16'sd12867);
        send_word(16'sd12868, 16'sd0, 16'sd12868);
        send_word(-16'sd12868, 16'sd0, -16'sd12868);
        send_word(16'sd0, 16'sh7FFF, 16'sd0);
        send_word(16'sd0, 16'sh8000, 16'sd0);
        send_word(16'sd0, 16'sd0, 16'sh7FFF);
        send_word(16'sd0, 16'sd0, 16'sh8000);
        send_word(16'sh8000, 16'sh8000, 16'sh7FFF);
        send_word(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_word(-16'sd1, -16'sd1, -16'sd1);

        // full gains: clip high and low
        set_gains(GainMax, GainMax, GainMax, GainMax, GainMax);
        send_word(16'sh8000, 16'sh8000, 16'sh7FFF);
        send_word(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_word(16'sd0, 16'sd0, 16'sd0);

        // zero gains, then writes to unmapped indexes must change nothing
        set_gains('0, '0, '0, '0, '0);
        send_word(16'sd12345, -16'sd2000, 16'sd300);
        for (k = FirstSpareIdx; k <= LastSpareIdx; k++) write_reg(3'(k), 18'($urandom));
        send_word(16'sd12345, -16'sd2000, 16'sd300);

        // random words under a sequence of gain settings
        for (int phase = 0; phase < NumPhases; phase++) begin
            case (phase)
                0: set_gains(ptgc_pkg::RstPropGain, ptgc_pkg::RstDerivGain,
                             ptgc_pkg::RstInertia, ptgc_pkg::RstDamping,
                             ptgc_pkg::RstGravityGain);
                1: set_gains(GainMax, GainMax, GainMax, GainMax, GainMax);
                2: set_gains('0, '0, '0, '0, '0);
                default: set_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                                   pick_gain());
            endcase
            for (int n = 0; n < PhaseWords; n++) begin
                if (n % StretchWords == 0)
                    idling <= (phase != NumPhases - 1) && ($urandom_range(0, 3) != 0);
                if (phase == 3 && n == PhaseWords / 2) drain();
                send_word(pick_word(1'b1), pick_word(1'b0), pick_word(1'b1));
            end
        end

        drain();
        repeat (2 * PipeDepth) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("pd_torque_gravity_comp_unit test passed");
        else
            $display("pd_torque_gravity_comp_unit test failed");
        $finish;
    end

endmodule
